[rtl/core/tapmidi_pkg.sv]
// ---------------------------------------------------------------------------
// Tap and MIDI clock tempo tracker package
// Shared widths, reset values, operation and register codes, payload types.
// ---------------------------------------------------------------------------
package tapmidi_pkg;

  localparam int TEMPO_W     = 17;
  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int OP_W        = 3;
  localparam int CFG_AW      = 3;

  localparam int TAP_WINDOW  = 4;
  localparam int TAP_AW      = (TAP_WINDOW > 1) ? $clog2(TAP_WINDOW) : 1;
  localparam int TAP_FILL_W  = $clog2(2 * TAP_WINDOW);

  localparam int TICK_RING   = 24;
  localparam int TICK_AW     = $clog2(TICK_RING);
  localparam int TICK_FILL_W = $clog2(TICK_RING + 1);

  localparam int DIV_STEPS   = TIME_W;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  // 60 s * 100 centi-BPM * 1000 ms per beat interval.
  localparam logic [TIME_W-1:0] TAP_SCALE  = TIME_W'(6000000);
  // Same scale times 23 intervals over 24 ticks per beat.
  localparam logic [TIME_W-1:0] TICK_SCALE = TIME_W'(5750000);

  localparam logic [TEMPO_W-1:0] TEMPO_MIN_RST     = TEMPO_W'(4000);
  localparam logic [TEMPO_W-1:0] TEMPO_MAX_RST     = TEMPO_W'(30000);
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT_RST = TEMPO_W'(12000);
  localparam logic [MS_W-1:0]    TAP_GAP_RST       = MS_W'(2000);
  localparam logic [MS_W-1:0]    SYNC_TIMEOUT_RST  = MS_W'(500);

  typedef enum logic [OP_W-1:0] {
    OP_TAP       = 3'd0,
    OP_TICK      = 3'd1,
    OP_CLK_RESET = 3'd2,
    OP_SET_TEMPO = 3'd3,
    OP_POLL      = 3'd4
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TEMPO_MIN     = 3'd0,
    CFG_TEMPO_MAX     = 3'd1,
    CFG_TEMPO_DEFAULT = 3'd2,
    CFG_TAP_GAP       = 3'd3,
    CFG_SYNC_TIMEOUT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPAN,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TIME_W-1:0]  now_ms;
    logic [TEMPO_W-1:0] tempo_value;
  } in_item_t;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo_now;
    logic [TEMPO_W-1:0] midi_tempo;
    logic               measured;
    logic               synced;
  } out_item_t;

  // The lower limit is applied first, so the upper limit wins when they cross.
  function automatic logic [TEMPO_W-1:0] clamp_tempo(
    input logic [TIME_W-1:0]  t,
    input logic [TEMPO_W-1:0] lo,
    input logic [TEMPO_W-1:0] hi
  );
    logic [TIME_W-1:0] c;
    c = t;
    if (c < {{(TIME_W-TEMPO_W){1'b0}}, lo}) c = {{(TIME_W-TEMPO_W){1'b0}}, lo};
    if (c > {{(TIME_W-TEMPO_W){1'b0}}, hi}) c = {{(TIME_W-TEMPO_W){1'b0}}, hi};
    return c[TEMPO_W-1:0];
  endfunction

endpackage

[rtl/core/tap_and_midi_clock_tempo_tracker_core.sv]
// ---------------------------------------------------------------------------
// Tap and MIDI clock tempo tracker core
// Tracks a working tempo, in centi-BPM, from tap events and MIDI clock messages.
// ---------------------------------------------------------------------------
// Flow: an input transfer is registered and goes to the exec state, then to the
// done state; a tap with two or more taps held or a tick that fills the ring passes
// the span check first, and a nonzero span goes through the 32-step restoring divider
// that turns the timestamp span into a tempo, then the apply state. One event is in
// flight; the next transfer is taken the cycle after the result is loaded into the output register.
// Synchronous active-low reset clears the control state, not the timestamp rings.
module tap_and_midi_clock_tempo_tracker_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tapmidi_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tapmidi_pkg::out_item_t                out_data,
  input  logic                                  cfg_we,
  input  logic [tapmidi_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [tapmidi_pkg::TEMPO_W-1:0]       cfg_wdata
);

  localparam int TW  = tapmidi_pkg::TIME_W;
  localparam int PW  = tapmidi_pkg::TEMPO_W;
  localparam int FW  = tapmidi_pkg::TAP_FILL_W;
  localparam int AW  = tapmidi_pkg::TAP_AW;
  localparam int KW  = tapmidi_pkg::TICK_AW;
  localparam int KFW = tapmidi_pkg::TICK_FILL_W;
  localparam int WIN = tapmidi_pkg::TAP_WINDOW;

  // Configuration registers
  logic [PW-1:0]               tempo_min_r;
  logic [PW-1:0]               tempo_max_r;
  logic [tapmidi_pkg::MS_W-1:0] gap_limit_r;
  logic [tapmidi_pkg::MS_W-1:0] sync_timeout_r;

  // Control and tracker state
  tapmidi_pkg::state_t state_r, state_nxt;
  logic [tapmidi_pkg::OP_W-1:0] op_r, op_nxt;
  logic [TW-1:0]   now_r, now_nxt;
  logic [PW-1:0]   val_r, val_nxt;
  logic [TW-1:0]   numer_r, numer_nxt;
  logic [TW-1:0]   div_r, div_nxt;
  logic [TW-1:0]   quo_r, quo_nxt;
  logic [TW-1:0]   rem_r, rem_nxt;
  logic [tapmidi_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic            measured_r, measured_nxt;
  logic [FW-1:0]   tap_fill_r, tap_fill_nxt;
  logic [TW-1:0]   last_tap_r, last_tap_nxt;
  logic [KW-1:0]   tick_idx_r, tick_idx_nxt;
  logic [KFW-1:0]  tick_fill_r, tick_fill_nxt;
  logic [TW-1:0]   last_tick_r, last_tick_nxt;
  logic [PW-1:0]   work_tempo_r, work_tempo_nxt;
  logic [PW-1:0]   clk_tempo_r, clk_tempo_nxt;
  logic            sync_r, sync_nxt;
  logic            out_valid_r, out_valid_nxt;
  tapmidi_pkg::out_item_t out_data_r, out_data_nxt;

  // Ring memories
  logic            tap_we;
  logic [AW-1:0]   tap_waddr, tap_raddr;
  logic [TW-1:0]   tap_rdata;
  logic            tick_we;
  logic [KW-1:0]   tick_raddr;
  logic [TW-1:0]   tick_rdata;

  // Tap window arithmetic
  logic            gap_hit;
  logic [FW-1:0]   fill0;
  logic [FW:0]     fill_inc;
  logic [FW-1:0]   fill1;
  logic [FW-1:0]   valid_cnt;
  logic [AW-1:0]   oldest;
  logic [AW-1:0]   wslot;
  logic [TW-1:0]   tap_numer;

  // Tick ring arithmetic
  logic [KW-1:0]   tick_idx_inc;
  logic [KFW-1:0]  tick_fill_inc;

  logic [TW-1:0]   span;
  logic [TW:0]     div_sh;
  logic [TW:0]     div_sub;
  logic [PW-1:0]   quo_clamped;
  logic            synced_now;

  tapmidi_ram #(
    .WIDTH(TW),
    .DEPTH(WIN)
  ) u_tap_ram (
    .clk  (clk),
    .we   (tap_we),
    .waddr(tap_waddr),
    .wdata(now_r),
    .raddr(tap_raddr),
    .rdata(tap_rdata)
  );

  tapmidi_ram #(
    .WIDTH(TW),
    .DEPTH(tapmidi_pkg::TICK_RING)
  ) u_tick_ram (
    .clk  (clk),
    .we   (tick_we),
    .waddr(tick_idx_r),
    .wdata(now_r),
    .raddr(tick_raddr),
    .rdata(tick_rdata)
  );

  assign in_ready  = (state_r == tapmidi_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // There is no tempo_default register: reset loads the package default tempo,
  // so a write to that address is taken and has no effect.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_min_r    <= tapmidi_pkg::TEMPO_MIN_RST;
      tempo_max_r    <= tapmidi_pkg::TEMPO_MAX_RST;
      gap_limit_r    <= tapmidi_pkg::TAP_GAP_RST;
      sync_timeout_r <= tapmidi_pkg::SYNC_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tapmidi_pkg::CFG_TEMPO_MIN:     tempo_min_r    <= cfg_wdata;
        tapmidi_pkg::CFG_TEMPO_MAX:     tempo_max_r    <= cfg_wdata;
        tapmidi_pkg::CFG_TEMPO_DEFAULT: ;
        tapmidi_pkg::CFG_TAP_GAP:       gap_limit_r    <= cfg_wdata[tapmidi_pkg::MS_W-1:0];
        tapmidi_pkg::CFG_SYNC_TIMEOUT:  sync_timeout_r <= cfg_wdata[tapmidi_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gap_hit  = (tap_fill_r != '0) &&
               ((now_r - last_tap_r) > {{(TW-tapmidi_pkg::MS_W){1'b0}}, gap_limit_r});
    fill0    = gap_hit ? '0 : tap_fill_r;
    wslot    = (fill0 >= FW'(WIN)) ? AW'(fill0 - FW'(WIN)) : AW'(fill0);
    fill_inc = {1'b0, fill0} + (FW+1)'(1);
    // The fill count folds back by one window once it reaches two windows.
    fill1    = (fill_inc >= (FW+1)'(2 * WIN)) ? FW'(fill_inc - (FW+1)'(WIN))
                                              : FW'(fill_inc);
    valid_cnt = (fill1 < FW'(WIN)) ? fill1 : FW'(WIN);
    oldest    = (fill1 >= FW'(WIN)) ? AW'(fill1 - FW'(WIN)) : '0;
    tap_numer = TW'(tapmidi_pkg::TAP_SCALE *
                    {{(TW-FW){1'b0}}, valid_cnt - FW'(1)});

    tick_idx_inc  = (tick_idx_r == KW'(tapmidi_pkg::TICK_RING - 1)) ? '0
                                                                    : tick_idx_r + KW'(1);
    tick_fill_inc = (tick_fill_r < KFW'(tapmidi_pkg::TICK_RING)) ? tick_fill_r + KFW'(1)
                                                                 : tick_fill_r;

    span    = now_r - ((op_r == tapmidi_pkg::OP_TICK) ? tick_rdata : tap_rdata);
    div_sh  = {rem_r, quo_r[TW-1]};
    div_sub = div_sh - {1'b0, div_r};
    quo_clamped = tapmidi_pkg::clamp_tempo(quo_r, tempo_min_r, tempo_max_r);
    synced_now  = sync_r &&
                  ((now_r - last_tick_r) <
                   {{(TW-tapmidi_pkg::MS_W){1'b0}}, sync_timeout_r});
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    val_nxt        = val_r;
    numer_nxt      = numer_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    measured_nxt   = measured_r;
    tap_fill_nxt   = tap_fill_r;
    last_tap_nxt   = last_tap_r;
    tick_idx_nxt   = tick_idx_r;
    tick_fill_nxt  = tick_fill_r;
    last_tick_nxt  = last_tick_r;
    work_tempo_nxt = work_tempo_r;
    clk_tempo_nxt  = clk_tempo_r;
    sync_nxt       = sync_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    tap_we         = 1'b0;
    tap_waddr      = wslot;
    tap_raddr      = oldest;
    tick_we        = 1'b0;
    tick_raddr     = tick_idx_inc;

    case (state_r)
      tapmidi_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.op;
          now_nxt      = in_data.now_ms;
          val_nxt      = in_data.tempo_value;
          measured_nxt = 1'b0;
          state_nxt    = tapmidi_pkg::ST_EXEC;
        end
      end

      tapmidi_pkg::ST_EXEC: begin
        state_nxt = tapmidi_pkg::ST_DONE;
        case (op_r)
          tapmidi_pkg::OP_TAP: begin
            // Store the tap and start reading the oldest one held.
            tap_we       = 1'b1;
            tap_fill_nxt = fill1;
            last_tap_nxt = now_r;
            numer_nxt    = tap_numer;
            if (fill1 >= FW'(2)) begin
              state_nxt = tapmidi_pkg::ST_SPAN;
            end
          end
          tapmidi_pkg::OP_TICK: begin
            tick_we       = 1'b1;
            tick_idx_nxt  = tick_idx_inc;
            tick_fill_nxt = tick_fill_inc;
            last_tick_nxt = now_r;
            numer_nxt     = tapmidi_pkg::TICK_SCALE;
            if (tick_fill_inc >= KFW'(tapmidi_pkg::TICK_RING)) begin
              state_nxt = tapmidi_pkg::ST_SPAN;
            end
          end
          tapmidi_pkg::OP_CLK_RESET: begin
            tick_fill_nxt = '0;
            tick_idx_nxt  = '0;
            sync_nxt      = 1'b0;
          end
          tapmidi_pkg::OP_SET_TEMPO: begin
            work_tempo_nxt = tapmidi_pkg::clamp_tempo({{(TW-PW){1'b0}}, val_r},
                                                      tempo_min_r, tempo_max_r);
            sync_nxt       = 1'b0;
            tap_fill_nxt   = '0;
          end
          default: ;
        endcase
      end

      tapmidi_pkg::ST_SPAN: begin
        if (span == '0) begin
          state_nxt = tapmidi_pkg::ST_DONE;
        end else begin
          div_nxt   = span;
          quo_nxt   = numer_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = tapmidi_pkg::ST_DIV;
        end
      end

      tapmidi_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (!div_sub[TW]) begin
          rem_nxt = div_sub[TW-1:0];
          quo_nxt = {quo_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[TW-1:0];
          quo_nxt = {quo_r[TW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + tapmidi_pkg::DIV_CW'(1);
        if (cnt_r == tapmidi_pkg::DIV_CW'(tapmidi_pkg::DIV_STEPS - 1)) begin
          state_nxt = tapmidi_pkg::ST_APPLY;
        end
      end

      tapmidi_pkg::ST_APPLY: begin
        work_tempo_nxt = quo_clamped;
        if (op_r == tapmidi_pkg::OP_TICK) begin
          clk_tempo_nxt = quo_clamped;
          sync_nxt      = 1'b1;
        end else begin
          measured_nxt = 1'b1;
          sync_nxt     = 1'b0;
        end
        state_nxt = tapmidi_pkg::ST_DONE;
      end

      tapmidi_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.tempo_now  = work_tempo_r;
          out_data_nxt.midi_tempo = clk_tempo_r;
          out_data_nxt.measured   = measured_r;
          out_data_nxt.synced     = synced_now;
          state_nxt               = tapmidi_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tapmidi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tapmidi_pkg::ST_IDLE;
      measured_r   <= 1'b0;
      tap_fill_r   <= '0;
      last_tap_r   <= '0;
      tick_idx_r   <= '0;
      tick_fill_r  <= '0;
      last_tick_r  <= '0;
      work_tempo_r <= tapmidi_pkg::TEMPO_DEFAULT_RST;
      clk_tempo_r  <= tapmidi_pkg::TEMPO_DEFAULT_RST;
      sync_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      measured_r   <= measured_nxt;
      tap_fill_r   <= tap_fill_nxt;
      last_tap_r   <= last_tap_nxt;
      tick_idx_r   <= tick_idx_nxt;
      tick_fill_r  <= tick_fill_nxt;
      last_tick_r  <= last_tick_nxt;
      work_tempo_r <= work_tempo_nxt;
      clk_tempo_r  <= clk_tempo_nxt;
      sync_r       <= sync_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    val_r      <= val_nxt;
    numer_r    <= numer_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // Only one event is in flight: a transfer in closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an event is in flight");

  // A finished event is loaded into the output register when there is room.
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tapmidi_pkg::ST_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished event not loaded into the output register");

  // A measured tempo never exceeds the upper limit in force when applied.
  a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tapmidi_pkg::ST_APPLY) |=> (work_tempo_r <= $past(tempo_max_r)))
    else $error("applied tempo above the upper limit");

  // Sync only latches on a MIDI clock tick.
  a_sync_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sync_r) |-> (op_r == tapmidi_pkg::OP_TICK))
    else $error("sync latched by an event other than a clock tick");
`endif

endmodule

[rtl/core/tapmidi_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tapmidi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo tracker core testbench
// Sends tap, clock tick, clock reset, set tempo and poll events through the
// input channel and predicts every result with a cycle-free model of the
// tracker. Each result transfer is checked field by field against that model
// over several limit settings, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import tapmidi_pkg::*;

  localparam int unsigned IDLE_PERCENT      = 27;
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES     = 48;
  localparam int unsigned WATCHDOG_LIMIT    = 5000;
  localparam int unsigned MAX_REPORTS       = 10;
  localparam int unsigned TEMPO_FIELD_MAX   = 99999;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [TEMPO_W-1:0] cfg_wdata = '0;

  tap_and_midi_clock_tempo_tracker_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Limits as the tracker currently holds them.
  logic [TEMPO_W-1:0] lim_lo = TEMPO_MIN_RST;
  logic [TEMPO_W-1:0] lim_hi = TEMPO_MAX_RST;
  logic [MS_W-1:0]    gap_ms = TAP_GAP_RST;
  logic [MS_W-1:0]    timeout_ms = SYNC_TIMEOUT_RST;

  // Tracker state.
  logic [TIME_W-1:0]  tap_times [TAP_WINDOW];
  int unsigned        tap_count = 0;
  logic [TIME_W-1:0]  last_tap_ms = '0;
  logic [TIME_W-1:0]  tick_times [TICK_RING];
  int unsigned        tick_pos = 0;
  int unsigned        tick_level = 0;
  logic [TIME_W-1:0]  last_tick_ms = '0;
  logic [TEMPO_W-1:0] beat_tempo = TEMPO_DEFAULT_RST;
  logic [TEMPO_W-1:0] clock_tempo = TEMPO_DEFAULT_RST;
  logic               sync_held = 1'b0;

  in_item_t          events_to_send [$];
  out_item_t         reports_due [$];
  logic [TIME_W-1:0] stamp = '0;
  int unsigned       events_queued = 0;
  bit                steady_flow = 1'b0;
  int unsigned       stall_requests = 0;
  int unsigned       stalls_taken = 0;
  int unsigned       stall_left = 0;
  int unsigned       failures = 0;
  int unsigned       quiet_cycles = 0;

  function automatic logic [TEMPO_W-1:0] clamp_to_limits(logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] c;
    c = t;
    if (c < TIME_W'(lim_lo)) c = TIME_W'(lim_lo);
    if (c > TIME_W'(lim_hi)) c = TIME_W'(lim_hi);
    return c[TEMPO_W-1:0];
  endfunction

  function automatic out_item_t report_for(in_item_t ev);
    out_item_t         rep;
    logic [TIME_W-1:0] span;
    int unsigned       held;
    rep = '0;
    case (ev.op)
      OP_TAP: begin
        span = ev.now_ms - last_tap_ms;
        if (tap_count != 0 && span > TIME_W'(gap_ms)) tap_count = 0;
        tap_times[tap_count % TAP_WINDOW] = ev.now_ms;
        tap_count++;
        if (tap_count >= 2 * TAP_WINDOW) tap_count -= TAP_WINDOW;
        last_tap_ms = ev.now_ms;
        if (tap_count >= 2) begin
          held = (tap_count < TAP_WINDOW) ? tap_count : TAP_WINDOW;
          span = ev.now_ms - tap_times[(tap_count - held) % TAP_WINDOW];
          if (span != 0) begin
            beat_tempo = clamp_to_limits(TAP_SCALE * TIME_W'(held - 1) / span);
            rep.measured = 1'b1;
            sync_held = 1'b0;
          end
        end
      end
      OP_TICK: begin
        last_tick_ms = ev.now_ms;
        tick_times[tick_pos] = ev.now_ms;
        tick_pos = (tick_pos + 1) % TICK_RING;
        if (tick_level < TICK_RING) tick_level++;
        // With a full ring the slot just past the newest tick is the oldest one.
        if (tick_level >= TICK_RING) begin
          span = ev.now_ms - tick_times[tick_pos];
          if (span != 0) begin
            beat_tempo = clamp_to_limits(TICK_SCALE / span);
            clock_tempo = beat_tempo;
            sync_held = 1'b1;
          end
        end
      end
      OP_CLK_RESET: begin
        tick_level = 0;
        tick_pos = 0;
        sync_held = 1'b0;
      end
      OP_SET_TEMPO: begin
        beat_tempo = clamp_to_limits(TIME_W'(ev.tempo_value));
        sync_held = 1'b0;
        tap_count = 0;
      end
      default: ;
    endcase
    span = ev.now_ms - last_tick_ms;
    rep.synced = sync_held && (span < TIME_W'(timeout_ms));
    rep.tempo_now = beat_tempo;
    rep.midi_tempo = clock_tempo;
    return rep;
  endfunction

  task automatic post_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] dt,
                            input int unsigned value);
    in_item_t ev;
    stamp += dt;
    ev.op = op;
    ev.now_ms = stamp;
    ev.tempo_value = TEMPO_W'(value);
    events_to_send.push_back(ev);
    events_queued++;
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= TEMPO_W'(value);
    case (addr)
      CFG_TEMPO_MIN:    lim_lo = TEMPO_W'(value);
      CFG_TEMPO_MAX:    lim_hi = TEMPO_W'(value);
      CFG_TAP_GAP:      gap_ms = MS_W'(value);
      CFG_SYNC_TIMEOUT: timeout_ms = MS_W'(value);
      // The default tempo is only loaded at reset, which happens once.
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input int unsigned lo, hi, dflt, gap, timeout);
    write_reg(CFG_TEMPO_MIN, lo);
    write_reg(CFG_TEMPO_MAX, hi);
    write_reg(CFG_TEMPO_DEFAULT, dflt);
    write_reg(CFG_TAP_GAP, gap);
    write_reg(CFG_SYNC_TIMEOUT, timeout);
    // Addresses past the last register must be ignored.
    write_reg(CFG_AW'(int'(CFG_SYNC_TIMEOUT) + $urandom_range(1, 3)),
              $urandom_range(0, TEMPO_FIELD_MAX));
    @(negedge clk);
  endtask

  // Sampled at the falling edge, so every update from the rising edge is visible.
  task automatic wait_drained();
    while (events_to_send.size() != 0 || in_valid || reports_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random_mix(input int unsigned amount);
    int unsigned       goal, pick, runs, lo, hi, step;
    logic [OP_W-1:0]   code;
    goal = events_queued + amount;
    while (events_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        // A burst of taps, mostly inside the gap limit.
        runs = $urandom_range(2, 9);
        hi = (gap_ms < 1500) ? gap_ms : 1500;
        lo = hi / 4;
        for (int i = 0; i < runs; i++) begin
          case ($urandom_range(0, 19))
            0:       step = 0;
            1:       step = gap_ms + $urandom_range(1, 3000);
            2:       step = gap_ms;
            default: step = $urandom_range(lo, hi);
          endcase
          post_event(OP_TAP, step, $urandom_range(0, TEMPO_FIELD_MAX));
        end
      end else if (pick < 62) begin
        // A run of clock ticks; now and then all of them share one timestamp.
        runs = $urandom_range(20, 40);
        if ($urandom_range(0, 11) == 0) begin
          lo = 0;
          hi = 0;
        end else begin
          lo = $urandom_range(8, 30);
          hi = lo + $urandom_range(0, 4);
        end
        for (int i = 0; i < runs; i++) begin
          step = (i == 0) ? $urandom_range(0, 200) : $urandom_range(lo, hi);
          post_event(OP_TICK, step, $urandom_range(0, TEMPO_FIELD_MAX));
        end
        if ($urandom_range(0, 1) != 0)
          post_event(OP_POLL, $urandom_range(0, 2 * timeout_ms),
                     $urandom_range(0, TEMPO_FIELD_MAX));
      end else if (pick < 72) begin
        code = OP_POLL;
        if ($urandom_range(0, 3) == 0)
          code = OP_W'($urandom_range(int'(OP_POLL) + 1, (1 << OP_W) - 1));
        post_event(code, $urandom_range(0, 2 * timeout_ms), $urandom_range(0, TEMPO_FIELD_MAX));
      end else if (pick < 82) begin
        case ($urandom_range(0, 9))
          0:       step = 0;
          1:       step = TEMPO_FIELD_MAX;
          default: step = $urandom_range(0, TEMPO_FIELD_MAX);
        endcase
        post_event(OP_SET_TEMPO, $urandom_range(0, 300), step);
      end else if (pick < 87) begin
        post_event(OP_CLK_RESET, $urandom_range(0, 100), $urandom_range(0, TEMPO_FIELD_MAX));
      end else begin
        stamp = $urandom();
        post_event(OP_W'($urandom_range(0, (1 << OP_W) - 1)), 0,
                   $urandom_range(0, TEMPO_FIELD_MAX));
      end
    end
  endtask

  // Input driver: predicts the result of every accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) reports_due.push_back(report_for(in_data));
      if (!in_valid || in_ready) begin
        if (events_to_send.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_data <= events_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output flow control.
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("%0t: result with none expected: tempo_now=%0d midi_tempo=%0d measured=%0b synced=%0b",
                     $realtime, out_data.tempo_now, out_data.midi_tempo, out_data.measured,
                     out_data.synced);
          failures++;
        end else begin
          want = reports_due.pop_front();
          if (out_data.tempo_now !== want.tempo_now || out_data.midi_tempo !== want.midi_tempo ||
              out_data.measured !== want.measured || out_data.synced !== want.synced) begin
            if (failures < MAX_REPORTS)
              $display("%0t: mismatch: expected tempo_now=%0d midi_tempo=%0d measured=%0b synced=%0b, got tempo_now=%0d midi_tempo=%0d measured=%0b synced=%0b",
                       $realtime, want.tempo_now, want.midi_tempo, want.measured, want.synced,
                       out_data.tempo_now, out_data.midi_tempo, out_data.measured,
                       out_data.synced);
            failures++;
          end
        end
      end
      if (stalls_taken != stall_requests) begin
        stalls_taken <= stalls_taken + 1;
        stall_left <= LONG_STALL_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned lo_pick;
    tap_times = '{default: '0};
    tick_times = '{default: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed events at the reset limits.
    post_event(OP_POLL, 0, TEMPO_FIELD_MAX);
    post_event(OP_TAP, 0, 0);
    post_event(OP_TAP, 0, 0);      // same timestamp, so no tempo yet
    post_event(OP_TAP, 500, 0);
    post_event(OP_TAP, 1, 0);      // window full, clamped to the upper limit
    post_event(OP_TAP, 400, 0);    // the window slides on by one tap
    post_event(OP_TAP, 2001, 0);   // just past the gap limit: window restarts
    post_event(OP_TAP, 2000, 0);   // exactly the gap limit, clamped to the lower limit
    post_event(OP_SET_TEMPO, 10, 0);
    post_event(OP_SET_TEMPO, 10, TEMPO_FIELD_MAX);
    post_event(OP_SET_TEMPO, 10, 15000);
    post_event(OP_TAP, 300, 0);    // set tempo emptied the tap window
    post_event(OP_TICK, 20, 0);
    post_event(OP_TICK, 20, 0);
    post_event(OP_CLK_RESET, 5, 0);
    post_event(OP_TICK, 20, 0);
    post_event(OP_POLL, 10, 0);
    for (int k = int'(OP_POLL) + 1; k < (1 << OP_W); k++)
      post_event(OP_W'(k), 7, $urandom_range(0, TEMPO_FIELD_MAX));
    // Taps across the timestamp wrap.
    stamp = 32'hFFFF_FFF0;
    post_event(OP_TAP, 0, 0);
    post_event(OP_TAP, 32, 0);
    wait_drained();

    queue_random_mix(130);
    wait_drained();

    // Widest limits, with no idling on either side.
    set_limits(1, TEMPO_FIELD_MAX, TEMPO_FIELD_MAX, 65535, 65535);
    steady_flow = 1'b1;
    queue_random_mix(80);
    wait_drained();
    steady_flow = 1'b0;

    // Crossed limits and the shortest windows; the output stalls for a long
    // stretch while events keep coming, so the input backs up.
    set_limits(30000, 5000, 1, 1, 1);
    queue_random_mix(60);
    stall_requests++;
    wait_drained();

    lo_pick = $urandom_range(1, 20000);
    set_limits(lo_pick, $urandom_range(lo_pick, TEMPO_FIELD_MAX), $urandom_range(1, TEMPO_FIELD_MAX),
               $urandom_range(500, 4000), $urandom_range(50, 2000));
    stamp = 32'hFFFF_0000;
    queue_random_mix(130);
    wait_drained();

    if (failures == 0 && reports_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
